// ===== rtl/core/spq_pkg.sv =====
// shared constants, codes and the command type of the priority task queue
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int LEVELS   = 3;
  localparam int TAG_BITS = 16;

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stream payload layout
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int PRIO_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_TAG_W   = 16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic                is_remove;
    logic [LVL_W-1:0]    lvl;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

endpackage

// ===== rtl/core/spq_front.sv =====
// front end: takes requests, clamps the priority to a level and builds commands
module spq_front (
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // task_tag, priority_req, zero pad
  input  logic [0:0]                          s_axis_tuser,  // mode
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output spq_pkg::cmd_t                       push_cmd_o
);
  import spq_pkg::*;

  logic [PRIO_W-1:0] prio_raw;
  logic [3:0]        prio_eff;

  assign prio_raw = s_axis_tdata[TAG_BITS +: PRIO_W];

  always_comb begin
    prio_eff = 4'(prio_raw);
    if (prio_raw == '0) begin
      prio_eff = 4'd1;
    end else if (4'(prio_raw) > 4'(LEVELS)) begin
      prio_eff = 4'(LEVELS);
    end
  end

  assign push_cmd_o.is_remove = (s_axis_tuser[0] == MODE_REMOVE);
  assign push_cmd_o.lvl       = LVL_W'(prio_eff - 4'd1);
  assign push_cmd_o.tag       = s_axis_tdata[TAG_BITS-1:0];

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

// ===== rtl/core/spq_cmd_fifo.sv =====
// short command queue that decouples the front end from the back end
module spq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  spq_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output spq_pkg::cmd_t pop_cmd_o
);
  import spq_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/spq_back.sv =====
// back end: per-level fifo bookkeeping, task store and the result register
module spq_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  spq_pkg::cmd_t                     cmd_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // removed_tag, removed_priority, pad
  output logic [spq_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                state_q, state_d;
  logic [IDX_W-1:0]    head_q  [LEVELS];
  logic [IDX_W-1:0]    head_d  [LEVELS];
  logic [IDX_W-1:0]    tail_q  [LEVELS];
  logic [IDX_W-1:0]    tail_d  [LEVELS];
  logic [CNT_W-1:0]    lcount_q [LEVELS];
  logic [CNT_W-1:0]    lcount_d [LEVELS];
  logic [CNT_W-1:0]    total_q, total_d;
  logic [LVL_W-1:0]    rd_lvl_q, rd_lvl_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_TAG_W-1:0] out_tag_q, out_tag_d;
  logic [PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic [TAG_BITS-1:0] mem_q [LEVELS*DEPTH];
  logic [TAG_BITS-1:0] rd_data_q;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;

  logic                out_free, do_cmd, found;
  logic [LVL_W-1:0]    sel_lvl;
  logic [CNT_W+3:0]    cnt_sum;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign do_cmd      = cmd_valid_i && cmd_ready_o;

  // lowest non-empty level wins
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (lcount_q[l] != '0) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(l);
      end
    end
  end

  assign mem_waddr = ADDR_W'(ADDR_W'(cmd_i.lvl) * ADDR_W'(DEPTH)) + ADDR_W'(tail_q[cmd_i.lvl]);
  assign mem_raddr = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(DEPTH)) + ADDR_W'(head_q[sel_lvl]);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    lcount_d     = lcount_q;
    total_d      = total_q;
    rd_lvl_d     = rd_lvl_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_tag_d    = out_tag_q;
    out_prio_d   = out_prio_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (do_cmd) begin
          if (!cmd_i.is_remove) begin
            out_valid_d = 1'b1;
            out_tag_d   = '0;
            out_prio_d  = '0;
            if (total_q == CNT_W'(DEPTH)) begin
              out_status_d = STAT_FULL;
            end else begin
              mem_we                = 1'b1;
              tail_d[cmd_i.lvl]     = (tail_q[cmd_i.lvl] == IDX_W'(DEPTH - 1)) ?
                                      '0 : tail_q[cmd_i.lvl] + 1'b1;
              lcount_d[cmd_i.lvl]   = lcount_q[cmd_i.lvl] + 1'b1;
              total_d               = total_q + 1'b1;
              out_status_d          = STAT_INSERTED;
            end
          end else if (!found) begin
            out_valid_d  = 1'b1;
            out_tag_d    = '0;
            out_prio_d   = '0;
            out_status_d = STAT_EMPTY;
          end else begin
            // tag comes out of the store in the next cycle
            mem_re            = 1'b1;
            head_d[sel_lvl]   = (head_q[sel_lvl] == IDX_W'(DEPTH - 1)) ?
                                '0 : head_q[sel_lvl] + 1'b1;
            lcount_d[sel_lvl] = lcount_q[sel_lvl] - 1'b1;
            total_d           = total_q - 1'b1;
            rd_lvl_d          = sel_lvl;
            state_d           = S_READ;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_tag_d    = OUT_TAG_W'(rd_data_q);
          out_prio_d   = PRIO_W'((LVL_W + 1)'(rd_lvl_q) + 1'b1);
          out_status_d = STAT_REMOVED;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]   <= '0;
        tail_q[l]   <= '0;
        lcount_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      lcount_q    <= lcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lvl_q     <= rd_lvl_d;
    out_tag_q    <= out_tag_d;
    out_prio_q   <= out_prio_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cmd_i.tag;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_prio_q, out_tag_q});
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    cnt_sum = '0;
    for (int l = 0; l < LEVELS; l++) begin
      cnt_sum = cnt_sum + (CNT_W + 4)'(lcount_q[l]);
    end
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(DEPTH))
    else $error("task count above capacity");

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sum == (CNT_W + 4)'(total_q))
    else $error("level counts disagree with total count");

  a_no_cmd_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !cmd_ready_o)
    else $error("command taken while a store read is pending");

  a_read_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_free) |=> (out_valid_q && out_status_q == STAT_REMOVED))
    else $error("pending removal did not reach the result register");

  a_removed_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_REMOVED) |-> out_prio_q != '0)
    else $error("removed task reported without a priority");

endmodule

// ===== rtl/core/stable_priority_task_queue_unit.sv =====
// top level of the stable priority task queue
//
// requests arrive on the s_axis channel: tuser is the mode (insert or remove),
// tdata carries the task tag and its priority (1 highest to 3 lowest; 0 acts
// as 1). every request yields one result on m_axis: tdata holds the removed
// tag and priority, tuser the status (inserted, removed, remove on empty,
// insert on full dropped). equal priorities leave in insertion order; all
// levels share a capacity of 16 tasks.
// a request passes a two-entry command queue, then the back end updates the
// per-level head/tail/count registers and the shared task store.
// an insert or a rejected request goes straight to the result register; a removal
// first reads the store (the read is registered) and its result follows from S_READ.
// inserts and rejected requests go one per cycle while the result register is free;
// no command is taken while a removal waits in S_READ on the single store read port.
// reset empties every level; the task store itself is not cleared.
// when m_axis_tready is low the result register holds its value, the back end
// stops, the command queue fills and then s_axis_tready falls.
module stable_priority_task_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // task_tag, priority_req, zero pad
  input  logic [0:0]                        s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // removed_tag, removed_priority, pad
  output logic [spq_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
  import spq_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  spq_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  spq_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  spq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_i         (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== bench/queue_checker.sv =====
// checker for the priority task queue: watches both streams, predicts and compares results
`timescale 1ns / 1ps

module queue_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // task_tag, priority_req, zero pad
  input  logic [0:0]                      s_axis_tuser,  // mode
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // removed_tag, removed_priority, pad
  input  logic [spq_pkg::STATUS_W-1:0]    m_axis_tuser,  // status
  output int                              fail_count_o,
  output int                              outstanding_o,
  output int                              removals_o,
  output int                              empty_hits_o,
  output int                              full_hits_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic [OUT_TAG_W-1:0] tag;
    logic [PRIO_W-1:0]    prio;
    logic [STATUS_W-1:0]  status;
  } outcome_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [PRIO_W-1:0]   prio;
  } held_task_t;

  // tasks in insertion order; removal picks the first one of the best level
  held_task_t held_tasks[$];
  outcome_t   expected_outcomes[$];

  int mismatches = 0;
  int removals   = 0;
  int empty_hits = 0;
  int full_hits  = 0;

  assign fail_count_o = mismatches;
  assign removals_o   = removals;
  assign empty_hits_o = empty_hits;
  assign full_hits_o  = full_hits;

  function automatic outcome_t queue_step(input logic mode, input logic [TAG_BITS-1:0] tag,
                                          input logic [PRIO_W-1:0] prio_raw);
    outcome_t   res;
    held_task_t entry;
    int         lvl;
    int         pick;
    res = '0;
    if (mode == MODE_INSERT) begin
      lvl = int'(prio_raw);
      if (lvl < 1) lvl = 1;
      if (lvl > LEVELS) lvl = LEVELS;
      if (held_tasks.size() >= DEPTH) begin
        res.status = STAT_FULL;
        full_hits++;
      end else begin
        entry.tag  = tag;
        entry.prio = PRIO_W'(lvl);
        held_tasks.push_back(entry);
        res.status = STAT_INSERTED;
      end
    end else begin
      pick = -1;
      foreach (held_tasks[i]) begin
        if (pick < 0 || held_tasks[i].prio < held_tasks[pick].prio) pick = i;
      end
      if (pick < 0) begin
        res.status = STAT_EMPTY;
        empty_hits++;
      end else begin
        res.tag    = OUT_TAG_W'(held_tasks[pick].tag);
        res.prio   = held_tasks[pick].prio;
        res.status = STAT_REMOVED;
        held_tasks.delete(pick);
        removals++;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      held_tasks.delete();
      expected_outcomes.delete();
      outstanding_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.push_back(queue_step(s_axis_tuser[0],
            s_axis_tdata[TAG_BITS-1:0], s_axis_tdata[TAG_BITS +: PRIO_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.tag    = m_axis_tdata[OUT_TAG_W-1:0];
        got.prio   = m_axis_tdata[OUT_TAG_W +: PRIO_W];
        got.status = m_axis_tuser;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: tag %h prio %0d status %0d",
                     got.tag, got.prio, got.status);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.tag !== want.tag || got.prio !== want.prio || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected tag %h prio %0d status %0d, got tag %h prio %0d status %0d",
                       want.tag, want.prio, want.status, got.tag, got.prio, got.status);
          end
        end
      end
      outstanding_o <= expected_outcomes.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// top of the priority task queue bench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 1950;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic [0:0]             s_user = MODE_INSERT;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [STATUS_W-1:0]    m_user;

  int send_idle  = 8;
  int recv_stall = 73;
  int cycles     = 0;
  int fail_count;
  int outstanding;
  int removals;
  int empty_hits;
  int full_hits;
  int accepted   = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  stable_priority_task_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  queue_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .removals_o    (removals),
    .empty_hits_o  (empty_hits),
    .full_hits_o   (full_hits)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(input logic mode, input logic [TAG_BITS-1:0] tag,
                              input logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(IN_TDATA_W-TAG_BITS-PRIO_W){1'b0}}, prio, tag};
    s_user  <= mode;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    accepted++;
  endtask

  initial begin
    int insert_pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, priority clamping, tag extremes, ties, full queue
    send_request(MODE_REMOVE, 16'hFFFF, 2'd3);
    send_request(MODE_INSERT, 16'h0000, 2'd0);
    send_request(MODE_INSERT, 16'hFFFF, 2'd3);
    send_request(MODE_INSERT, 16'h5555, 2'd2);
    send_request(MODE_INSERT, 16'hAAAA, 2'd1);
    send_request(MODE_INSERT, 16'h00FF, 2'd1);
    send_request(MODE_REMOVE, 16'h0000, 2'd0);
    send_request(MODE_REMOVE, 16'h1234, 2'd2);
    // three left; fill up to capacity, then push two more into the full queue
    for (int i = 0; i < DEPTH - 3 + 2; i++)
      send_request(MODE_INSERT, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
    send_request(MODE_REMOVE, 16'h0000, 2'd0);
    send_request(MODE_REMOVE, 16'hFFFF, 2'd3);

    // random: three idle profiles, insert bias drifting so the queue swings full and empty
    insert_pct = 50;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle  = 8;
          recv_stall = 73;
        end
        1: begin
          send_idle  = 73;
          recv_stall = 8;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_REQS / 3; n++) begin
        if (n % 32 == 0) insert_pct = 20 + 30 * $urandom_range(0, 2);
        send_request(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                     16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
      end
    end
    s_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d requests sent through three handshake idle profiles", accepted);
    $display("%0d removals, %0d removes on empty, %0d inserts dropped on full",
             removals, empty_hits, full_hits);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
